// File: hdl/bqlp_pkg.sv
`timescale 1ns / 1ps

package bqlp_pkg;

  localparam int COEF_W    = 24;
  localparam int HIST_W    = 24;
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int COEF_FRAC = COEF_W - 2;
  localparam int GAIN_FRAC = 12;
  localparam int CFG_W     = (COEF_W > GAIN_W) ? COEF_W : GAIN_W;
  localparam int CFG_IDX_W = 3;
  // multiplier operand A carries a coefficient or the zero-extended gain
  localparam int MA_W      = (COEF_W > GAIN_W) ? COEF_W : GAIN_W + 1;
  localparam int PROD_W    = MA_W + HIST_W;
  // each truncated coefficient term fits HIST_W+2 bits, five of them HIST_W+4
  localparam int ACC_W     = HIST_W + 4;
  localparam int OUT_LIMIT = 32767;

  localparam int NUM_STEPS = 10;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd5;

  localparam logic [COEF_W-1:0] B0_RESET   = COEF_W'(1) << COEF_FRAC;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1) << GAIN_FRAC;

  typedef enum logic [2:0] {
    A_B0, A_B1, A_B2, A_A1, A_A2, A_GAIN
  } asel_t;

  typedef enum logic [2:0] {
    B_X, B_X1, B_X2, B_Y1, B_Y2
  } bsel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    COND_NEXT, COND_WAIT_IN, COND_WAIT_OUT
  } cond_t;

  typedef struct packed {
    asel_t             asel;
    bsel_t             bsel;
    logic              mul_en;
    acc_op_t           acc_op;
    logic              hist_upd;
    logic              out_load;
    cond_t             cond;
    logic [STEP_W-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic        [GAIN_W-1:0] gain;
  } cfg_t;

  // Microprogram: one control word per step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w.asel     = A_B0;
    w.bsel     = B_X;
    w.mul_en   = 1'b0;
    w.acc_op   = ACC_HOLD;
    w.hist_upd = 1'b0;
    w.out_load = 1'b0;
    w.cond     = COND_NEXT;
    w.tgt      = '0;
    case (step)
      4'd0: w.cond = COND_WAIT_IN;
      4'd1: begin
        w.asel = A_B0; w.bsel = B_X; w.mul_en = 1'b1;
      end
      4'd2: begin
        w.asel = A_B1; w.bsel = B_X1; w.mul_en = 1'b1; w.acc_op = ACC_LOAD;
      end
      4'd3: begin
        w.asel = A_B2; w.bsel = B_X2; w.mul_en = 1'b1; w.acc_op = ACC_ADD;
      end
      4'd4: begin
        w.asel = A_A1; w.bsel = B_Y1; w.mul_en = 1'b1; w.acc_op = ACC_ADD;
      end
      4'd5: begin
        w.asel = A_A2; w.bsel = B_Y2; w.mul_en = 1'b1; w.acc_op = ACC_SUB;
      end
      4'd6: w.acc_op = ACC_SUB;
      4'd7: w.hist_upd = 1'b1;
      4'd8: begin
        w.asel = A_GAIN; w.bsel = B_Y1; w.mul_en = 1'b1;
      end
      4'd9: begin
        w.out_load = 1'b1; w.cond = COND_WAIT_OUT; w.tgt = '0;
      end
      default: begin
        w.cond = COND_WAIT_OUT; w.tgt = '0;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hdl/biquad_lowpass_gain_saturate_unit.sv
`timescale 1ns / 1ps
// Channel   Ports                                 Direction
// input     in_valid, in_stall, in_sample_in      sample in, stall driven here
// result    out_valid, out_stall, out_sample_out  sample out, stall from sink
// config    cfg_we, cfg_index, cfg_wdata          register write, no read-back
//
// An item runs through 10 microprogram steps, 0 to 9: one shared multiplier walks
// the five biquad taps and then the gain, one product in each step that multiplies.
// The result register loads at step 9; the next input is taken back at step 0.
// Reset (synchronous, rst_n low) clears histories, step counter and output valid,
// loads unity b0 and gain. While the output register still holds an untaken result,
// the sequencer waits at step 9.

module biquad_lowpass_gain_saturate_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [bqlp_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bqlp_pkg::SAMPLE_W-1:0]  out_sample_out,
  input  logic                                  cfg_we,
  input  logic        [bqlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [bqlp_pkg::CFG_W-1:0]     cfg_wdata
);

  bqlp_pkg::cfg_t  cfg_r;
  bqlp_pkg::cfg_t  cfg_nxt;
  bqlp_pkg::ctrl_t ctrl;
  logic            out_busy;

  // register file: bits above a register's width are dropped,
  // unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        bqlp_pkg::REG_B0:   cfg_nxt.b0   = cfg_wdata[bqlp_pkg::COEF_W-1:0];
        bqlp_pkg::REG_B1:   cfg_nxt.b1   = cfg_wdata[bqlp_pkg::COEF_W-1:0];
        bqlp_pkg::REG_B2:   cfg_nxt.b2   = cfg_wdata[bqlp_pkg::COEF_W-1:0];
        bqlp_pkg::REG_A1:   cfg_nxt.a1   = cfg_wdata[bqlp_pkg::COEF_W-1:0];
        bqlp_pkg::REG_A2:   cfg_nxt.a2   = cfg_wdata[bqlp_pkg::COEF_W-1:0];
        bqlp_pkg::REG_GAIN: cfg_nxt.gain = cfg_wdata[bqlp_pkg::GAIN_W-1:0];
        default:            cfg_nxt      = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0   <= bqlp_pkg::B0_RESET;
      cfg_r.b1   <= '0;
      cfg_r.b2   <= '0;
      cfg_r.a1   <= '0;
      cfg_r.a2   <= '0;
      cfg_r.gain <= bqlp_pkg::GAIN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // microprogram sequencer: step counter, control ROM, wait conditions
  bqlp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  // datapath: shared multiplier, accumulator, histories, output register
  bqlp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_sample_in   (in_sample_in),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .out_busy       (out_busy)
  );

endmodule

// File: hdl/bqlp_seq.sv
`timescale 1ns / 1ps

module bqlp_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_busy,
  output logic            in_stall,
  output bqlp_pkg::ctrl_t ctrl
);

  logic [bqlp_pkg::STEP_W-1:0] step_r;
  logic [bqlp_pkg::STEP_W-1:0] step_nxt;
  bqlp_pkg::ctrl_t             word;

  assign word = bqlp_pkg::ucode(step_r);

  always_comb begin
    ctrl          = word;
    ctrl.out_load = word.out_load && !out_busy;
  end

  assign in_stall = (word.cond != bqlp_pkg::COND_WAIT_IN);

  always_comb begin
    case (word.cond)
      bqlp_pkg::COND_NEXT:     step_nxt = bqlp_pkg::STEP_W'(step_r + 1'b1);
      bqlp_pkg::COND_WAIT_IN:  step_nxt = in_valid ? bqlp_pkg::STEP_W'(step_r + 1'b1) : step_r;
      bqlp_pkg::COND_WAIT_OUT: step_nxt = out_busy ? step_r : word.tgt;
      default:                 step_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: hdl/bqlp_dp.sv
`timescale 1ns / 1ps

module bqlp_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bqlp_pkg::ctrl_t                     ctrl,
  input  bqlp_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  input  logic signed [bqlp_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [bqlp_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_busy
);

  localparam int HW = bqlp_pkg::HIST_W;
  localparam int AW = bqlp_pkg::ACC_W;
  localparam int PW = bqlp_pkg::PROD_W;
  localparam int SW = bqlp_pkg::SAMPLE_W;
  localparam logic signed [AW-1:0] HMAX = (AW'(1) << (HW - 1)) - AW'(1);
  localparam logic signed [AW-1:0] HMIN = ~HMAX;
  localparam logic signed [PW-1:0] OMAX = PW'(bqlp_pkg::OUT_LIMIT);
  localparam logic signed [PW-1:0] OMIN = -OMAX;

  logic signed [SW-1:0]           x_r, x1_r, x2_r;
  logic signed [HW-1:0]           y1_r, y2_r;
  logic signed [PW-1:0]           prod_r, prod_nxt;
  logic signed [AW-1:0]           acc_r, acc_nxt;
  logic signed [bqlp_pkg::MA_W-1:0] op_a;
  logic signed [HW-1:0]           op_b;
  logic signed [AW-1:0]           term;
  logic signed [PW-1:0]           gterm;
  logic signed [HW-1:0]           y_sat;
  logic signed [SW-1:0]           out_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]           out_r;
  logic                           x_load;

  assign x_load   = in_valid && (ctrl.cond == bqlp_pkg::COND_WAIT_IN);
  assign out_busy = out_valid_r && out_stall;

  always_comb begin
    case (ctrl.asel)
      bqlp_pkg::A_B0:   op_a = bqlp_pkg::MA_W'(cfg.b0);
      bqlp_pkg::A_B1:   op_a = bqlp_pkg::MA_W'(cfg.b1);
      bqlp_pkg::A_B2:   op_a = bqlp_pkg::MA_W'(cfg.b2);
      bqlp_pkg::A_A1:   op_a = bqlp_pkg::MA_W'(cfg.a1);
      bqlp_pkg::A_A2:   op_a = bqlp_pkg::MA_W'(cfg.a2);
      bqlp_pkg::A_GAIN: op_a = bqlp_pkg::MA_W'({1'b0, cfg.gain});
      default:          op_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.bsel)
      bqlp_pkg::B_X:  op_b = HW'(x_r);
      bqlp_pkg::B_X1: op_b = HW'(x1_r);
      bqlp_pkg::B_X2: op_b = HW'(x2_r);
      bqlp_pkg::B_Y1: op_b = y1_r;
      bqlp_pkg::B_Y2: op_b = y2_r;
      default:        op_b = '0;
    endcase
  end

  assign prod_nxt = PW'(op_a * op_b);

  // arithmetic shifts give floor truncation
  assign term  = AW'(prod_r >>> bqlp_pkg::COEF_FRAC);
  assign gterm = prod_r >>> bqlp_pkg::GAIN_FRAC;

  always_comb begin
    case (ctrl.acc_op)
      bqlp_pkg::ACC_LOAD: acc_nxt = term;
      bqlp_pkg::ACC_ADD:  acc_nxt = acc_r + term;
      bqlp_pkg::ACC_SUB:  acc_nxt = acc_r - term;
      default:            acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    if (acc_r > HMAX) begin
      y_sat = HW'(HMAX);
    end else if (acc_r < HMIN) begin
      y_sat = HW'(HMIN);
    end else begin
      y_sat = HW'(acc_r);
    end
  end

  always_comb begin
    if (gterm > OMAX) begin
      out_nxt = SW'(OMAX);
    end else if (gterm < OMIN) begin
      out_nxt = SW'(OMIN);
    end else begin
      out_nxt = SW'(gterm);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctrl.hist_upd) begin
        x2_r <= x1_r;
        x1_r <= x_r;
        y2_r <= y1_r;
        y1_r <= y_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (x_load) begin
      x_r <= in_sample_in;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    if (ctrl.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> !(out_valid_r && out_stall))
    else $error("held result overwritten");

  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.hist_upd |=> (x1_r == $past(x_r)) && (y2_r == $past(y1_r)))
    else $error("history shift wrong");

  a_out_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r != SW'(OMIN - PW'(1))))
    else $error("output outside symmetric range");

  a_load_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.acc_op == bqlp_pkg::ACC_LOAD) |-> $past(ctrl.mul_en))
    else $error("accumulator loaded without product");

endmodule
